FILE: rtl/crce_pkg.sv
// Shared types, constants and helper functions of the configurable CRC engine.
package crce_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int CRC_W       = 32;
  localparam int MIN_WIDTH   = 4;
  localparam int DATA_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CRCW_W      = 6;
  localparam int SHIFT_W     = 5;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECTED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XOR_OUT    = 3'd4;

  // Reset preset: CRC-32.
  localparam logic [CRCW_W-1:0] RST_CRC_WIDTH  = 6'd32;
  localparam logic [CRC_W-1:0]  RST_POLY       = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0]  RST_INIT_VALUE = 32'hFFFF_FFFF;
  localparam logic              RST_REFLECTED  = 1'b1;
  localparam logic [CRC_W-1:0]  RST_XOR_OUT    = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]  RST_CRC_REG    = 32'hFFFF_FFFF;

  // One queued request.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } item_t;

  // Settings in working form, as the datapath uses them.
  typedef struct packed {
    logic               reload;
    logic               reflected;
    logic [SHIFT_W-1:0] shift;
    logic [CRC_W-1:0]   mask;
    logic [CRC_W-1:0]   poly_w;
    logic [CRC_W-1:0]   start;
    logic [CRC_W-1:0]   xor_out;
  } cfg_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/configurable_crc_engine_unit.sv
// Top level of the configurable byte-serial CRC engine.
// A byte accepted at the input passes the request queue and the output register to reach m_tdata.
// Throughput: one byte per cycle while m_tready holds; eight-step XOR-shift network is combinational.
// A two-entry queue between intake and datapath lets either side stall alone.
// Reset (rst, synchronous): CRC-32 preset, running register all ones, queue and output empty.
// A valid configuration write reloads the running register in the cycle after the write.
module configurable_crc_engine_unit import crce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // last_byte
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [31:0] crc_value
  output logic                  m_tlast    // frame_end
);

  cfg_t      cfg;
  q_status_t q_status;
  item_t     push_item;
  item_t     head;
  logic      push;
  logic      pop;

  // Hold configuration and admit requests while the queue has room.
  crce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_data    (s_tdata),
    .s_last    (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  // Buffer requests so the datapath can stall on the result side.
  crce_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // Advance the CRC one byte per popped request and register the result.
  crce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_crc    (m_tdata),
    .m_last   (m_tlast)
  );

  // Never pop an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("pop from empty request queue");

  // A fresh result never carries bits above the configured width.
  assert property (@(posedge clk) disable iff (rst)
    pop |=> ((m_tdata & ~$past(cfg.mask)) == '0))
    else $error("result has bits above CRC width");

  // A full queue refuses new requests; a non-full queue takes them.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !q_status.full) |=> !($past(q_status.empty) && q_status.empty))
    else $error("accepted request did not reach the queue");

endmodule

FILE: rtl/crce_front.sv
// Front end: configuration registers, working-form settings and request intake.
module crce_front import crce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_data,
  input  logic                  s_last,
  input  q_status_t             q_status,
  output logic                  push,
  output item_t                 push_item,
  output cfg_t                  cfg
);

  logic [CRCW_W-1:0] crc_width;
  logic [CRC_W-1:0]  poly;
  logic [CRC_W-1:0]  init_value;
  logic              reflected;
  logic [CRC_W-1:0]  xor_out;
  logic              reload;
  logic              hit;

  logic [CRCW_W-1:0]  eff_w;
  logic [CRCW_W-1:0]  shift_full;
  logic [SHIFT_W-1:0] shift;
  logic [CRC_W-1:0]   mask;

  always_comb begin
    case (cfg_index)
      REG_CRC_WIDTH, REG_POLY, REG_INIT_VALUE, REG_REFLECTED, REG_XOR_OUT: hit = 1'b1;
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width  <= RST_CRC_WIDTH;
      poly       <= RST_POLY;
      init_value <= RST_INIT_VALUE;
      reflected  <= RST_REFLECTED;
      xor_out    <= RST_XOR_OUT;
      reload     <= 1'b0;
    end else begin
      // Flag a reload of the running register for the cycle after any valid write.
      reload <= cfg_we && hit;
      if (cfg_we) begin
        case (cfg_index)
          REG_CRC_WIDTH:  crc_width  <= cfg_data[CRCW_W-1:0];
          REG_POLY:       poly       <= cfg_data[CRC_W-1:0];
          REG_INIT_VALUE: init_value <= cfg_data[CRC_W-1:0];
          REG_REFLECTED:  reflected  <= cfg_data[0];
          REG_XOR_OUT:    xor_out    <= cfg_data[CRC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Saturate the width and derive alignment: reflected runs right-aligned,
  // normal form runs left-aligned so the feedback tap is always bit 31.
  always_comb begin
    if (crc_width < CRCW_W'(MIN_WIDTH)) begin
      eff_w = CRCW_W'(MIN_WIDTH);
    end else if (crc_width > CRCW_W'(MAX_WIDTH)) begin
      eff_w = CRCW_W'(MAX_WIDTH);
    end else begin
      eff_w = crc_width;
    end
    shift_full = CRCW_W'(CRC_W) - eff_w;
    shift      = shift_full[SHIFT_W-1:0];
    mask       = {CRC_W{1'b1}} >> shift;
  end

  always_comb begin
    cfg.reload    = reload;
    cfg.reflected = reflected;
    cfg.shift     = shift;
    cfg.mask      = mask;
    cfg.xor_out   = xor_out;
    if (reflected) begin
      cfg.poly_w = rev32(poly & mask) >> shift;
      cfg.start  = rev32(init_value & mask) >> shift;
    end else begin
      cfg.poly_w = poly << shift;
      cfg.start  = init_value << shift;
    end
  end

  assign s_tready       = !q_status.full;
  assign push           = s_tvalid && s_tready;
  assign push_item.data = s_data;
  assign push_item.last = s_last;

endmodule

FILE: rtl/crce_fifo.sv
// Short request queue between the front end and the CRC datapath.
module crce_fifo import crce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t q_status
);

  item_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  function automatic logic [FIFO_PTR_W-1:0] bump(input logic [FIFO_PTR_W-1:0] p);
    if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head           = slots[rd_ptr];
  assign q_status.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign q_status.empty = (count == '0);

endmodule

FILE: rtl/crce_back.sv
// Back end: running CRC register, byte-wide XOR-shift network and output register.
module crce_back import crce_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  item_t            head,
  input  q_status_t        q_status,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [CRC_W-1:0] m_crc,
  output logic             m_last
);

  logic [CRC_W-1:0] crc_reg;
  logic [CRC_W-1:0] crc_reg_next;
  logic [CRC_W-1:0] result;
  logic             fb;

  // Eight dependent shift steps, one per message bit.
  always_comb begin
    crc_reg_next = crc_reg;
    fb           = 1'b0;
    for (int i = 0; i < DATA_W; i++) begin
      if (cfg.reflected) begin
        fb           = crc_reg_next[0] ^ head.data[i];
        crc_reg_next = (crc_reg_next >> 1) ^ (fb ? cfg.poly_w : '0);
      end else begin
        fb           = crc_reg_next[CRC_W-1] ^ head.data[DATA_W-1-i];
        crc_reg_next = (crc_reg_next << 1) ^ (fb ? cfg.poly_w : '0);
      end
    end
    if (cfg.reflected) begin
      result = (crc_reg_next ^ cfg.xor_out) & cfg.mask;
    end else begin
      result = ((crc_reg_next >> cfg.shift) ^ cfg.xor_out) & cfg.mask;
    end
  end

  assign pop = !q_status.empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg  <= RST_CRC_REG;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg.reload) begin
        crc_reg <= cfg.start;
      end else if (pop) begin
        crc_reg <= head.last ? cfg.start : crc_reg_next;
      end
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_crc  <= result;
      m_last <= head.last;
    end
  end

endmodule

FILE: verif/tb_configurable_crc_engine_unit.sv
// Self-checking testbench of the configurable byte-serial CRC engine.
`timescale 1ns / 100ps

module tb_configurable_crc_engine_unit;
  import crce_pkg::*;

  // Run shape.
  localparam int ITEMS_TOTAL = 1450;   // requests in the whole run, directed part included
  localparam int CALM_TAIL   = 150;    // last requests are sent and taken with no idling
  localparam int SETTLE      = 4;      // cycles past the last result before a register write
  localparam int DRAIN_EXTRA = 20;     // cycles past the last result before the verdict
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_REGS    = 5;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  // Kinds of rows in the directed table.
  localparam bit ROW_REQ = 1'b0;
  localparam bit ROW_CFG = 1'b1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // [7:0] data_byte
  logic                  s_tlast;   // last_byte
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;   // [31:0] crc_value
  logic                  m_tlast;   // frame_end

  configurable_crc_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // One expected result: CRC so far and the frame-close flag.
  typedef struct {
    logic [31:0] crc;
    logic        fin;
  } crc_result_t;

  crc_result_t pending_crcs [$];

  // Row of the directed table. A request row carries its byte in val[7:0];
  // "typed" rows carry a hand-known CRC that overrides the predictor.
  typedef struct packed {
    bit                    kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           val;
    logic                  last;
    bit                    typed;
    logic [31:0]           crc;
  } dir_row_t;

  localparam int DIR_ROWS = 39;
  dir_row_t dir_tab [DIR_ROWS] = '{
    // Reset preset (CRC-32): single extreme bytes, then the standard check string.
    '{ROW_REQ, '0, 32'h00, 1'b1, 1'b1, 32'hD202_EF8D},
    '{ROW_REQ, '0, 32'hFF, 1'b1, 1'b1, 32'hFF00_0000},
    '{ROW_REQ, '0, 32'h31, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h32, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h33, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h34, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h35, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h36, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h37, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h38, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h39, 1'b1, 1'b1, 32'hCBF4_3926},
    // 16-bit unreflected, all-zero init and final XOR.
    '{ROW_CFG, REG_CRC_WIDTH,  32'd16,   1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_POLY,       32'h1021, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_INIT_VALUE, 32'h0,    1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_REFLECTED,  32'h0,    1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_XOR_OUT,    32'h0,    1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'hFF, 1'b1, 1'b0, 32'h0},
    // Width below range saturates to the minimum; all-ones settings cut to width.
    '{ROW_CFG, REG_CRC_WIDTH,  32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_POLY,       32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_INIT_VALUE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_XOR_OUT,    32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'hFF, 1'b1, 1'b0, 32'h0},
    '{ROW_CFG, REG_REFLECTED,  32'h1, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'hA5, 1'b1, 1'b0, 32'h0},
    // Width above range saturates to 32; upper data bits of the write are dropped.
    '{ROW_CFG, REG_CRC_WIDTH,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_REFLECTED,  32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_INIT_VALUE, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_XOR_OUT,    32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_POLY,       32'h04C1_1DB7, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'hFF, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h5A, 1'b1, 1'b0, 32'h0},
    // Writes past the register list change nothing.
    '{ROW_CFG, REG_SPARE_LO, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_SPARE_HI, 32'h0,         1'b0, 1'b0, 32'h0},
    // A valid write in the middle of a frame aborts it and reloads the register.
    '{ROW_REQ, '0, 32'h12, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, REG_XOR_OUT,    32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, '0, 32'h34, 1'b1, 1'b0, 32'h0}
  };

  // Settings of common CRC variants, picked for half of the random phases.
  typedef struct packed {
    logic [CRCW_W-1:0] w;
    logic [31:0]       poly;
    logic [31:0]       init;
    logic              refl;
    logic [31:0]       xo;
  } crc_preset_t;

  localparam int NUM_PRESETS = 10;
  crc_preset_t crc_presets [NUM_PRESETS] = '{
    '{6'd32, 32'h04C1_1DB7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{6'd16, 32'h1021,      32'h0,         1'b0, 32'h0},
    '{6'd16, 32'h8005,      32'hFFFF,      1'b1, 32'h0},
    '{6'd16, 32'h3D65,      32'h0,         1'b1, 32'hFFFF},
    '{6'd8,  32'h07,        32'h0,         1'b0, 32'h55},
    '{6'd8,  32'h31,        32'h0,         1'b1, 32'h0},
    '{6'd5,  32'h05,        32'h1F,        1'b1, 32'h1F},
    '{6'd5,  32'h15,        32'h0,         1'b1, 32'h0},
    '{6'd7,  32'h09,        32'h0,         1'b0, 32'h0},
    '{6'd4,  32'h03,        32'h0,         1'b1, 32'h0}
  };

  // Predictor copy of the configuration and of the running register.
  logic [CRCW_W-1:0] p_width;
  logic [31:0]       p_poly;
  logic [31:0]       p_init;
  logic              p_refl;
  logic [31:0]       p_xor;
  logic [31:0]       p_run;

  // Side info driven along with each request.
  bit                req_typed;
  logic [31:0]       req_crc;

  int  fail_count;
  int  sent_reqs;
  int  cycle_count;
  int  stall_left;
  bit  idle_on;

  // Effective width: saturate into the supported range.
  function automatic int unsigned width_in_use(logic [CRCW_W-1:0] w);
    int unsigned n;
    n = w;
    if (n < MIN_WIDTH) n = MIN_WIDTH;
    if (n > MAX_WIDTH) n = MAX_WIDTH;
    if (n > CRC_W) n = CRC_W;
    return n;
  endfunction

  function automatic logic [31:0] low_mask(int unsigned n);
    logic [63:0] m;
    m = (64'd1 << n) - 64'd1;
    return m[31:0];
  endfunction

  // Reverse the low n bits.
  function automatic logic [31:0] mirror(logic [31:0] v, int unsigned n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (v[i]) r[n-1-i] = 1'b1;
    end
    return r;
  endfunction

  // Register value at the start of a frame, in working form.
  function automatic logic [31:0] frame_start();
    int unsigned n;
    logic [31:0] v;
    n = width_in_use(p_width);
    v = p_init & low_mask(n);
    return p_refl ? mirror(v, n) : v;
  endfunction

  // Shift one byte into the running register, eight XOR-shift steps.
  function automatic logic [31:0] shift_byte(logic [31:0] r_in, logic [7:0] b);
    int unsigned n;
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] r;
    logic        fb;
    n = width_in_use(p_width);
    m = low_mask(n);
    r = r_in & m;
    p = p_poly & m;
    if (p_refl) begin
      p = mirror(p, n);
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ b[i];
        r  = r >> 1;
        if (fb) r ^= p;
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        fb = r[n-1] ^ b[7-i];
        r  = (r << 1) & m;
        if (fb) r ^= p;
      end
    end
    return r & m;
  endfunction

  // Extremes and random values for the wide registers.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts, none in the calm tail.
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Predictor and scoreboard. Everything is sampled at the rising edge, so
  // all values seen here are the ones the block itself registers.
  always @(posedge clk) begin
    crc_result_t exp_r;
    crc_result_t new_r;
    logic [31:0] nxt;
    if (rst) begin
      p_width = RST_CRC_WIDTH;
      p_poly  = RST_POLY;
      p_init  = RST_INIT_VALUE;
      p_refl  = RST_REFLECTED;
      p_xor   = RST_XOR_OUT;
      p_run   = RST_CRC_REG;
    end else begin
      // Compare each delivered result with the oldest expectation.
      if (m_tvalid && m_tready) begin
        if (pending_crcs.size() == 0) begin
          $error("unexpected result: crc_value %h frame_end %b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          exp_r = pending_crcs.pop_front();
          if (m_tdata !== exp_r.crc) begin
            $error("crc_value: expected %h, got %h", exp_r.crc, m_tdata);
            fail_count++;
          end
          if (m_tlast !== exp_r.fin) begin
            $error("frame_end: expected %b, got %b", exp_r.fin, m_tlast);
            fail_count++;
          end
        end
      end
      // Track register writes; a valid index reloads the running register.
      if (cfg_we) begin
        case (cfg_index)
          REG_CRC_WIDTH:  p_width = cfg_data[CRCW_W-1:0];
          REG_POLY:       p_poly  = cfg_data;
          REG_INIT_VALUE: p_init  = cfg_data;
          REG_REFLECTED:  p_refl  = cfg_data[0];
          REG_XOR_OUT:    p_xor   = cfg_data;
          default: ;
        endcase
        if (cfg_index < REG_SPARE_LO) p_run = frame_start();
      end
      // Predict the result of each accepted request.
      if (s_tvalid && s_tready) begin
        nxt       = shift_byte(p_run, s_tdata);
        new_r.crc = req_typed ? req_crc
                              : (nxt ^ p_xor) & low_mask(width_in_use(p_width));
        new_r.fin = s_tlast;
        pending_crcs.push_back(new_r);
        p_run = s_tlast ? frame_start() : nxt;
      end
    end
  end

  // Offer one request, with an optional gap first; return after acceptance,
  // at the next falling edge, with valid still high.
  task automatic send_req(input logic [7:0] b, input logic l, input bit typed,
                          input logic [31:0] tcrc);
    idle_on = (sent_reqs < ITEMS_TOTAL - CALM_TAIL);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= b;
    s_tlast   <= l;
    req_typed <= typed;
    req_crc   <= tcrc;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_reqs++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result has come, then let the
  // block settle before anything touches its registers.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_crcs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One register write; give the reload time to take effect afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    int          phase;
    int          n_reqs;
    int          flen;
    int          pos;
    int          sel;
    logic        lst;
    logic [31:0] wv;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    req_typed  = 1'b0;
    req_crc    = '0;
    fail_count = 0;
    sent_reqs  = 0;
    cycle_count = 0;
    stall_left = 0;
    idle_on    = 1'b1;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: walk the table.
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[k].idx, dir_tab[k].val);
      end else begin
        send_req(dir_tab[k].val[7:0], dir_tab[k].last, dir_tab[k].typed, dir_tab[k].crc);
      end
    end

    // Random part: phases of settings, each followed by a burst of frames.
    phase = 0;
    while (sent_reqs < ITEMS_TOTAL) begin
      settle();
      if ($urandom_range(0, 1) == 0) begin
        sel = $urandom_range(0, NUM_PRESETS - 1);
        write_reg(REG_CRC_WIDTH, {26'($urandom_range(0, 3)), crc_presets[sel].w});
        write_reg(REG_POLY, crc_presets[sel].poly);
        write_reg(REG_INIT_VALUE, crc_presets[sel].init);
        write_reg(REG_REFLECTED, {31'h0, crc_presets[sel].refl});
        write_reg(REG_XOR_OUT, crc_presets[sel].xo);
      end else begin
        // Random settings; each register is skipped now and then.
        if ($urandom_range(0, 3) != 0) begin
          wv = $urandom;
          wv[CRCW_W-1:0] = ($urandom_range(0, 3) == 0)
                           ? CRCW_W'($urandom_range(0, 63))
                           : CRCW_W'($urandom_range(MIN_WIDTH, CRC_W));
          write_reg(REG_CRC_WIDTH, wv);
        end
        if ($urandom_range(0, 3) != 0) write_reg(REG_POLY, $urandom);
        if ($urandom_range(0, 3) != 0) write_reg(REG_INIT_VALUE, pick_word());
        if ($urandom_range(0, 3) != 0) write_reg(REG_REFLECTED, $urandom);
        if ($urandom_range(0, 3) != 0) write_reg(REG_XOR_OUT, pick_word());
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, REG_SPARE_HI)), $urandom);
      end
      repeat (2) @(negedge clk);

      // Frames of mostly short random length; a phase may end mid-frame,
      // so the next phase's writes abort it.
      n_reqs = $urandom_range(20, 60);
      pos    = 0;
      flen   = 1;
      for (int j = 0; j < n_reqs && sent_reqs < ITEMS_TOTAL; j++) begin
        if (pos == 0) begin
          flen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        end
        lst = (pos == flen - 1);
        if ($urandom_range(0, 19) == 0) lst = 1'($urandom_range(0, 1));
        pos = lst ? 0 : pos + 1;
        // Pause the sender until the result side has caught up.
        if (idle_on && ((phase == 3 && j == n_reqs / 2) || $urandom_range(0, 99) == 0)) begin
          s_tvalid <= 1'b0;
          while (pending_crcs.size() != 0) @(negedge clk);
        end
        send_req(8'($urandom_range(0, 255)), lst, 1'b0, 32'h0);
      end
      phase++;
    end

    // Drain and give the pipeline time to show any stray result.
    s_tvalid <= 1'b0;
    while (pending_crcs.size() != 0) @(negedge clk);
    repeat (DRAIN_EXTRA) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
